[rtl/rmlv_pkg.sv]
// rmlv_pkg: shared types, codes and default sizes for the region majority vote block
// no dependencies; used by rmlv_ctrl, rmlv_dp and region_majority_label_vote_top
package rmlv_pkg;

	localparam int MAX_REGIONS_DEF = 64;
	localparam int NUM_LABELS_DEF  = 256;
	localparam int COUNT_BITS_DEF  = 20;

	localparam int ACTION_W  = 2;
	localparam int REGION_W  = 6;
	localparam int LABEL_W   = 8;
	localparam int RCOUNT_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam logic [RCOUNT_W-1:0] REGION_COUNT_RST  = 7'd64;
	localparam logic [LABEL_W-1:0]  INVALID_LABEL_RST = 8'd0;

	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INVALID_LABEL = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic add_rd;
		logic scan_start;
		logic scan_rd;
		logic clr_start;
		logic clr_wr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic region_ok;
		logic add_busy;
		logic out_busy;
		logic scan_last;
		logic clr_last;
	} sts_t;

endpackage

[rtl/rmlv_ctrl.sv]
// rmlv_ctrl: controller state machine for the region majority vote block
// depends on rmlv_pkg; drives commands into rmlv_dp and reads its status
module rmlv_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rmlv_pkg::ACTION_W-1:0] action,
	input  rmlv_pkg::sts_t                sts,
	output logic                          in_stall,
	output rmlv_pkg::cmd_t                cmd
);

	rmlv_pkg::state_t state_q;
	rmlv_pkg::state_t state_nx;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmlv_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		accept   = 1'b0;
		case (state_q)
			rmlv_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nx = rmlv_pkg::ST_IDLE;
				end
			end
			rmlv_pkg::ST_IDLE: begin
				in_stall = ((action != rmlv_pkg::ACT_ADD) && sts.add_busy) ||
					((action == rmlv_pkg::ACT_QUERY) && sts.out_busy);
				accept = in_valid && !in_stall;
				if (accept) begin
					case (action)
						rmlv_pkg::ACT_ADD: begin
							cmd.add_rd = 1'b1;
						end
						rmlv_pkg::ACT_QUERY: begin
							cmd.scan_start = 1'b1;
							state_nx = sts.region_ok ? rmlv_pkg::ST_SCAN : rmlv_pkg::ST_DONE;
						end
						rmlv_pkg::ACT_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_nx = rmlv_pkg::ST_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			rmlv_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_nx = rmlv_pkg::ST_DRAIN;
				end
			end
			rmlv_pkg::ST_DRAIN: begin
				state_nx = rmlv_pkg::ST_DONE;
			end
			rmlv_pkg::ST_DONE: begin
				cmd.fin  = 1'b1;
				state_nx = rmlv_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rmlv_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/rmlv_dp.sv]
// rmlv_dp: vote counter memory, add pipeline with forwarding, label scan and result register
// depends on rmlv_pkg; commanded by rmlv_ctrl
module rmlv_dp #(
	parameter int MAX_REGIONS = rmlv_pkg::MAX_REGIONS_DEF,
	parameter int NUM_LABELS  = rmlv_pkg::NUM_LABELS_DEF,
	parameter int COUNT_BITS  = rmlv_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmlv_pkg::cmd_t                 cmd,
	output rmlv_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic [rmlv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmlv_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic [rmlv_pkg::REGION_W-1:0]  region_index,
	input  logic [rmlv_pkg::LABEL_W-1:0]   pixel_label,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [rmlv_pkg::REGION_W-1:0]  queried_region,
	output logic [rmlv_pkg::LABEL_W-1:0]   majority_label,
	output logic [COUNT_BITS-1:0]          vote_count,
	output logic                           valid_res
);

	localparam int RB    = $clog2(MAX_REGIONS);
	localparam int LB    = $clog2(NUM_LABELS);
	localparam int AW    = RB + LB;
	localparam int DEPTH = 1 << AW;
	localparam logic [LB-1:0] LAB_LAST = LB'(NUM_LABELS - 1);

	logic [COUNT_BITS-1:0] mem [DEPTH];

	logic [rmlv_pkg::RCOUNT_W-1:0] rc_q;
	logic [rmlv_pkg::LABEL_W-1:0]  il_q;

	logic                  region_ok;
	logic                  label_ok;
	logic [AW-1:0]         in_addr;

	logic                  valid_s1;
	logic [AW-1:0]         addr_s1;
	logic                  valid_s2;
	logic [AW-1:0]         addr_s2;
	logic [COUNT_BITS-1:0] data_s2;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;

	logic [AW-1:0]         clr_addr_q;

	logic [RB-1:0]         qreg_q;
	logic [rmlv_pkg::REGION_W-1:0] qidx_q;
	logic [LB-1:0]         lab_q;
	logic                  rvalid_s1;
	logic [LB-1:0]         lab_s1;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [LB-1:0]         best_lab_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;
	logic                  mem_re;
	logic [AW-1:0]         mem_ra;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= rmlv_pkg::REGION_COUNT_RST;
			il_q <= rmlv_pkg::INVALID_LABEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rmlv_pkg::REG_REGION_COUNT:  rc_q <= cfg_data[rmlv_pkg::RCOUNT_W-1:0];
				rmlv_pkg::REG_INVALID_LABEL: il_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign region_ok = (rmlv_pkg::RCOUNT_W'(region_index) < rc_q) &&
		(int'(region_index) < MAX_REGIONS);
	assign label_ok  = int'(pixel_label) < NUM_LABELS;
	assign in_addr   = {RB'(region_index), LB'(pixel_label)};

	// add path: read, then saturating write with one-deep forwarding
	assign cur = (valid_s2 && (addr_s2 == addr_s1)) ? data_s2 : rd_q;
	assign inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			valid_s1  <= cmd.add_rd && region_ok && label_ok;
			valid_s2  <= valid_s1;
			rvalid_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= in_addr;
		addr_s2 <= addr_s1;
		data_s2 <= inc;
		lab_s1  <= lab_q;
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// label scan of one region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_q <= '0;
		end else if (cmd.scan_start) begin
			lab_q <= '0;
		end else if (cmd.scan_rd) begin
			lab_q <= lab_q + LB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			qreg_q     <= RB'(region_index);
			qidx_q     <= region_index;
			best_cnt_q <= '0;
			best_lab_q <= '0;
		end else if (rvalid_s1 && (rd_q > best_cnt_q)) begin
			best_cnt_q <= rd_q;
			best_lab_q <= lab_s1;
		end
	end

	// single memory port pair
	always_comb begin
		mem_we = valid_s1 || cmd.clr_wr;
		mem_wa = cmd.clr_wr ? clr_addr_q : addr_s1;
		mem_wd = cmd.clr_wr ? '0 : inc;
		mem_re = cmd.add_rd || cmd.scan_rd;
		mem_ra = cmd.scan_rd ? {qreg_q, lab_q} : in_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.fin) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			queried_region <= qidx_q;
			majority_label <= (best_cnt_q == '0) ? il_q : rmlv_pkg::LABEL_W'(best_lab_q);
			vote_count     <= best_cnt_q;
			valid_res      <= best_cnt_q != '0;
		end
	end

	always_comb begin
		sts.region_ok = region_ok;
		sts.add_busy  = valid_s1;
		sts.out_busy  = out_valid;
		sts.scan_last = lab_q == LAB_LAST;
		sts.clr_last  = clr_addr_q == {AW{1'b1}};
	end

endmodule

[rtl/region_majority_label_vote_top.sv]
// region_majority_label_vote_top: per-region majority label vote block
// Input word: action, region_index, pixel_label on in_valid / in_stall. Add words
// stream at one per cycle while no query or clear is in progress, through a
// read-modify-write pipe with forwarding; a pixel whose region or label is out of
// range is dropped. A query scans the labels of one region, one counter read per
// cycle, over the single counter memory read port, before its result word appears
// on out_valid / out_stall; an out-of-range query skips the scan. A clear word
// sweeps the whole memory of 2^(clog2(MAX_REGIONS) + clog2(NUM_LABELS)) entries,
// 16384 at the default sizes, one entry per cycle, with in_stall high meanwhile.
// After reset the same clearing pass runs before the first word is taken; register
// writes on cfg_we are taken at any time. The result register holds the answer
// while out_stall is high; adds and clears keep flowing, and a further query waits
// until the pending result is taken. Queries and clears also wait on a pending add write.
// depends on rmlv_pkg, rmlv_ctrl, rmlv_dp
module region_majority_label_vote_top #(
	parameter int MAX_REGIONS = rmlv_pkg::MAX_REGIONS_DEF,
	parameter int NUM_LABELS  = rmlv_pkg::NUM_LABELS_DEF,
	parameter int COUNT_BITS  = rmlv_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rmlv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmlv_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rmlv_pkg::ACTION_W-1:0]  action,
	input  logic [rmlv_pkg::REGION_W-1:0]  region_index,
	input  logic [rmlv_pkg::LABEL_W-1:0]   pixel_label,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rmlv_pkg::REGION_W-1:0]  queried_region,
	output logic [rmlv_pkg::LABEL_W-1:0]   majority_label,
	output logic [COUNT_BITS-1:0]          vote_count,
	output logic                           valid_res
);

	rmlv_pkg::cmd_t cmd;
	rmlv_pkg::sts_t sts;

	rmlv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	rmlv_dp #(
		.MAX_REGIONS (MAX_REGIONS),
		.NUM_LABELS  (NUM_LABELS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.region_index   (region_index),
		.pixel_label    (pixel_label),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.queried_region (queried_region),
		.majority_label (majority_label),
		.vote_count     (vote_count),
		.valid_res      (valid_res)
	);

endmodule
